### rtl/afe_pkg.sv
// Shared types, constants and microcode for the affine transform engine.
// Used by afe_mul, afe_sqrt, afe_div, afe_ctrl, afe_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package afe_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int DW              = 64;
  localparam int PW              = 128;
  localparam int PC_W            = 7;

  // program entry points in the microcode store
  localparam int P_IDENT = 0;
  localparam int P_TRANS = 2;
  localparam int P_ROT   = 4;
  localparam int P_XF    = 97;
  localparam int P_LAST  = 116;

  typedef enum logic [2:0] {
    CMD_IDENT = 3'd0,
    CMD_TRANS = 3'd1,
    CMD_ROT   = 3'd2,
    CMD_POINT = 3'd3,
    CMD_VEC   = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    U_NOP, U_LOAD, U_IDENT, U_TRANS, U_CLRSUM, U_CLRACC, U_MUL, U_SQRT, U_DIV,
    U_CHECK, U_OMC, U_WRNM, U_COMMIT, U_ADDT, U_OUTW, U_EMIT, U_END
  } uop_op_t;

  typedef enum logic [2:0] {
    SK_IN, SK_UNIT, SK_OMC, SK_T, SK_NORM, SK_R, SK_MAT
  } src_kind_t;

  typedef enum logic [2:0] {
    DK_SUM, DK_ACC, DK_T, DK_PP, DK_UNIT, DK_NORM
  } dst_kind_t;

  typedef struct packed {
    src_kind_t  kind;
    logic [3:0] idx;
  } src_t;

  typedef struct packed {
    dst_kind_t  kind;
    logic [3:0] idx;
  } dst_t;

  typedef struct packed {
    uop_op_t    op;
    src_t       a;
    src_t       b;
    dst_t       dst;
    logic [3:0] idx;
  } uop_t;

  typedef struct packed {
    logic unit_done;
    logic degenerate;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_EMIT
  } ctrl_state_t;

  function automatic uop_t mk(uop_op_t op, src_kind_t ak, int ai, src_kind_t bk, int bi,
                              dst_kind_t dk, int di, int ix);
    uop_t u;
    u.op       = op;
    u.a.kind   = ak;
    u.a.idx    = 4'(ai);
    u.b.kind   = bk;
    u.b.idx    = 4'(bi);
    u.dst.kind = dk;
    u.dst.idx  = 4'(di);
    u.idx      = 4'(ix);
    return u;
  endfunction

  function automatic uop_t mk_op(uop_op_t op, int ix);
    return mk(op, SK_IN, 0, SK_IN, 0, DK_SUM, 0, ix);
  endfunction

  // Microcode store: identity, translate, rotate, transform.
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    int   o;
    int   st;
    int   pa;
    int   pb;
    u  = mk_op(U_END, 0);
    o  = int'(pc);
    pa = 0;
    pb = 0;
    if (o == P_IDENT) begin
      u = mk_op(U_IDENT, 0);
    end else if (o == P_TRANS) begin
      u = mk_op(U_TRANS, 0);
    end else if (o >= P_ROT && o < P_XF) begin
      o = o - P_ROT;
      if (o == 0 || o == 5) begin
        u = mk_op(U_CLRSUM, 0);
      end else if (o >= 1 && o <= 3) begin
        u = mk(U_MUL, SK_IN, o - 1, SK_IN, o - 1, DK_SUM, 0, 0);
      end else if (o == 4) begin
        u = mk(U_SQRT, SK_IN, 0, SK_IN, 0, DK_NORM, 0, 0);
      end else if (o == 6 || o == 7) begin
        u = mk(U_MUL, SK_IN, o - 3, SK_IN, o - 3, DK_SUM, 0, 0);
      end else if (o == 8) begin
        u = mk(U_SQRT, SK_IN, 0, SK_IN, 0, DK_NORM, 1, 0);
      end else if (o == 9) begin
        u = mk_op(U_CHECK, 0);
      end else if (o >= 10 && o <= 14) begin
        u = mk(U_DIV, SK_IN, o - 10, SK_NORM, (o < 13) ? 0 : 1, DK_UNIT, o - 10, 0);
      end else if (o == 15) begin
        u = mk_op(U_OMC, 0);
      end else if (o >= 16 && o <= 27) begin
        st = (o - 16) >> 1;
        case (st)
          0: begin pa = 0; pb = 0; end
          1: begin pa = 1; pb = 1; end
          2: begin pa = 2; pb = 2; end
          3: begin pa = 0; pb = 1; end
          4: begin pa = 0; pb = 2; end
          default: begin pa = 1; pb = 2; end
        endcase
        if (((o - 16) & 1) == 0)
          u = mk(U_MUL, SK_UNIT, pa, SK_UNIT, pb, DK_T, 0, 0);
        else
          u = mk(U_MUL, SK_T, 0, SK_OMC, 0, DK_PP, st, 0);
      end else if (o >= 28 && o <= 30) begin
        // z*s, y*s, x*s
        u = mk(U_MUL, SK_UNIT, 30 - o, SK_UNIT, 4, DK_PP, o - 22, 0);
      end else if (o >= 31 && o <= 90) begin
        for (int e = 0; e < 12; e++) begin
          if (o >= 31 + e * 5 && o < 36 + e * 5) begin
            st = o - 31 - e * 5;
            if (st == 0)
              u = mk_op(U_CLRACC, 0);
            else if (st == 4)
              u = mk_op(U_WRNM, e);
            else
              u = mk(U_MUL, SK_R, (e >> 2) * 3 + st - 1, SK_MAT, (st - 1) * 4 + (e & 3),
                     DK_ACC, 0, 0);
          end
        end
      end else if (o == 91) begin
        u = mk_op(U_COMMIT, 0);
      end
    end else if (o >= P_XF) begin
      o = o - P_XF;
      if (o < 18) begin
        for (int i = 0; i < 3; i++) begin
          if (o >= i * 6 && o < i * 6 + 6) begin
            st = o - i * 6;
            if (st == 0)
              u = mk_op(U_CLRACC, 0);
            else if (st == 4)
              u = mk_op(U_ADDT, i * 4 + 3);
            else if (st == 5)
              u = mk_op(U_OUTW, i);
            else
              u = mk(U_MUL, SK_MAT, i * 4 + st - 1, SK_IN, st - 1, DK_ACC, 0, 0);
          end
        end
      end else if (o == 18) begin
        u = mk_op(U_EMIT, 0);
      end
    end
    return u;
  endfunction

endpackage
`default_nettype wire

### rtl/affine_transform_engine.sv
// 3D affine transform engine, top level: controller plus datapath.
// Depends on afe_pkg, afe_ctrl, afe_dp.
//
// Input channel in_*: one command per transaction. in_tuser holds the
// command code, in_tdata the coordinates and the cosine/sine pair.
// Commands: identity, translate and rotate update the internal 3x4 matrix
// and return nothing; transform point and rotate vector return one
// transaction on out_* with the three saturated coordinates.
// Configuration channel cfg_*: one 16-bit zero tolerance, always ready;
// write it only while the engine is idle.
// Work per command: transform runs nine digit-serial multiplies on the shared
// multiplier; rotate runs two 32-step roots, five 64-step divides and 56
// multiplies, all on single shared units. One command is worked at a time;
// in_tready is high only while the controller is idle.
// Reset loads the identity matrix and a tolerance of 1 and empties the
// output register. A stalled receiver holds the result in the output
// register; a new command is still accepted, and its own result waits until
// that register has been taken.
`timescale 1ns / 1ps
`default_nettype none
module affine_transform_engine #(
  parameter int FRAC_BITS   = afe_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = afe_pkg::COORD_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [159:0] in_tdata,   // coord_x, coord_y, coord_z, cos_part, sin_part
  input  wire logic [2:0]   in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // out_x, out_y, out_z
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data
);
  import afe_pkg::*;

  uop_t     dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  afe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  afe_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .in_user  (in_tuser),
    .in_data  (in_tdata),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_tdata)
  );

endmodule
`default_nettype wire

### rtl/afe_mul.sv
// Shared magnitude multiplier, 64 x 64 bits, one 16-bit digit of b per cycle.
// Depends on afe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afe_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [afe_pkg::DW-1:0] a_mag,
  input  wire logic [afe_pkg::DW-1:0] b_mag,
  output logic                       done,
  output logic [afe_pkg::PW-1:0]     prod
);
  import afe_pkg::*;

  logic [DW-1:0] a_r;
  logic [DW-1:0] b_r;
  logic [PW-1:0] acc_r;
  logic [1:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW+15:0] part;

  assign part = a_r * b_r[DW-1:DW-16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a_mag;
        b_r    <= b_mag;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // most significant digit first
        acc_r <= {acc_r[PW-17:0], 16'h0000} + PW'(part);
        b_r   <= {b_r[DW-17:0], 16'h0000};
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

### rtl/afe_sqrt.sv
// Bit-pair integer square root of a 64-bit value, 32 iterations.
// Depends on afe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afe_sqrt (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [afe_pkg::DW-1:0] n_in,
  output logic                        done,
  output logic [afe_pkg::DW-1:0]      root
);
  import afe_pkg::*;

  logic [DW-1:0] n_r;
  logic [DW-1:0] res_r;
  logic [DW-1:0] bit_r;
  logic [4:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= n_in;
        res_r  <= '0;
        bit_r  <= DW'(1) << (DW - 2);
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r;

endmodule
`default_nettype wire

### rtl/afe_div.sv
// Restoring unsigned divider, 64-bit quotient, one bit per cycle.
// Depends on afe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afe_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [afe_pkg::DW-1:0] num,
  input  wire logic [afe_pkg::DW-1:0] den,
  output logic                        done,
  output logic [afe_pkg::DW-1:0]      quo
);
  import afe_pkg::*;

  logic [DW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_r, num_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
        quo_r <= {quo_r[DW-2:0], fits};
        num_r <= {num_r[DW-2:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

### rtl/afe_ctrl.sv
// Controller: walks the microcode store, sequences the arithmetic units and
// owns the handshakes. Depends on afe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [2:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output afe_pkg::uop_t          dp_cmd,
  input  wire afe_pkg::dp_stat_t dp_stat
);
  import afe_pkg::*;

  ctrl_state_t     state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_valid_r, out_valid_nxt;
  uop_t            uop;
  logic            slot_free;
  logic            emit_go;

  assign uop       = ucode(pc_r);
  assign slot_free = !out_valid_r || out_tready;
  assign emit_go   = (state_r == ST_EMIT) && slot_free;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_ISSUE;
          case (in_tuser)
            CMD_IDENT: pc_nxt = PC_W'(P_IDENT);
            CMD_TRANS: pc_nxt = PC_W'(P_TRANS);
            CMD_ROT:   pc_nxt = PC_W'(P_ROT);
            CMD_POINT, CMD_VEC: pc_nxt = PC_W'(P_XF);
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ISSUE: begin
        case (uop.op)
          U_END:   state_nxt = ST_IDLE;
          U_EMIT:  state_nxt = ST_EMIT;
          U_MUL, U_SQRT, U_DIV: state_nxt = ST_WAIT;
          U_CHECK: begin
            if (dp_stat.degenerate) state_nxt = ST_IDLE;
            else pc_nxt = pc_r + 1'b1;
          end
          default: pc_nxt = pc_r + 1'b1;
        endcase
      end
      ST_WAIT: begin
        if (dp_stat.unit_done) begin
          state_nxt = ST_ISSUE;
          pc_nxt    = pc_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_ISSUE;
          pc_nxt    = pc_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = emit_go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    dp_cmd     = mk_op(U_NOP, 0);
    case (state_r)
      ST_IDLE:  if (in_tvalid) dp_cmd = mk_op(U_LOAD, 0);
      // output register is loaded only from ST_EMIT, once the slot is free
      ST_ISSUE: dp_cmd = (uop.op == U_EMIT) ? mk_op(U_NOP, 0) : uop;
      ST_EMIT:  if (slot_free) dp_cmd = mk_op(U_EMIT, 0);
      default:  dp_cmd = mk_op(U_NOP, 0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_wait_on_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> (uop.op == U_MUL || uop.op == U_SQRT || uop.op == U_DIV))
    else $error("waiting on a single-cycle micro-op");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.unit_done |-> state_r == ST_WAIT)
    else $error("unit finished while controller not waiting");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> pc_r <= PC_W'(P_LAST))
    else $error("program counter ran past the microcode store");

endmodule
`default_nettype wire

### rtl/afe_dp.sv
// Datapath: matrix, rotation temporaries, operand selection, product
// rounding and saturation, with the shared multiplier, root and divider.
// Depends on afe_pkg, afe_mul, afe_sqrt, afe_div.
`timescale 1ns / 1ps
`default_nettype none
module afe_dp #(
  parameter int FRAC_BITS   = afe_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = afe_pkg::COORD_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire afe_pkg::uop_t cmd,
  output afe_pkg::dp_stat_t  stat,
  input  wire logic [2:0]    in_user,
  input  wire logic [159:0]  in_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  output logic [95:0]        out_data
);
  import afe_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam logic signed [DW-1:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic [DW-1:0] PROD_LIM = 64'd1 << 61;

  logic [2:0]              cmd_r;
  logic signed [31:0]      vin_r   [5];
  logic signed [DW-1:0]    unit_r  [5];
  logic signed [DW-1:0]    pp_r    [9];
  logic signed [DW-1:0]    omc_r, t_r, acc_r;
  logic [DW-1:0]           norm_r  [2];
  logic [DW-1:0]           sum_r;
  logic signed [CW-1:0]    mat_r   [12];
  logic signed [CW-1:0]    nm_r    [12];
  logic signed [31:0]      stage_r [3];
  logic signed [31:0]      out_r   [3];
  logic [15:0]             tol_r;
  dst_t                    mul_dst_r, div_dst_r, sqrt_dst_r;
  logic                    mul_neg_r, div_neg_r;

  logic signed [DW-1:0] r_w [9];
  logic signed [DW-1:0] a_val, b_val;
  logic [DW-1:0]        a_mag, b_mag;
  logic                 mul_start, sqrt_start, div_start;
  logic                 mul_done, sqrt_done, div_done;
  logic [PW-1:0]        mul_prod;
  logic [DW-1:0]        sqrt_root, div_quo;
  logic [PW-1:0]        prod_sh;
  logic [DW-1:0]        q_mag;
  logic signed [DW-1:0] q_val;

  function automatic logic signed [DW-1:0] ext_cw(input logic signed [CW-1:0] v);
    return DW'(v);
  endfunction

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [DW-1:0] get_src(input src_t s);
    logic signed [DW-1:0] v;
    case (s.kind)
      SK_IN:   v = DW'(vin_r[s.idx[2:0]]);
      SK_UNIT: v = unit_r[s.idx[2:0]];
      SK_OMC:  v = omc_r;
      SK_T:    v = t_r;
      SK_NORM: v = norm_r[s.idx[0]];
      SK_R:    v = r_w[s.idx];
      SK_MAT:  v = ext_cw(mat_r[s.idx]);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rodrigues terms: pp holds xx,yy,zz,xy,xz,yz (times 1-c) then zs,ys,xs
  always_comb begin
    r_w[0] = unit_r[3] + pp_r[0];
    r_w[1] = pp_r[3] - pp_r[6];
    r_w[2] = pp_r[4] + pp_r[7];
    r_w[3] = pp_r[3] + pp_r[6];
    r_w[4] = unit_r[3] + pp_r[1];
    r_w[5] = pp_r[5] - pp_r[8];
    r_w[6] = pp_r[4] - pp_r[7];
    r_w[7] = pp_r[5] + pp_r[8];
    r_w[8] = unit_r[3] + pp_r[2];
  end

  always_comb begin
    a_val = get_src(cmd.a);
    b_val = get_src(cmd.b);
    a_mag = a_val[DW-1] ? DW'(-a_val) : DW'(a_val);
    b_mag = b_val[DW-1] ? DW'(-b_val) : DW'(b_val);
  end

  assign mul_start  = (cmd.op == U_MUL);
  assign sqrt_start = (cmd.op == U_SQRT);
  assign div_start  = (cmd.op == U_DIV);

  afe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  afe_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n_in  (sum_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  afe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (a_mag << FRAC_BITS),
    .den   (b_val),
    .done  (div_done),
    .quo   (div_quo)
  );

  // fixed-point product: shift, clamp magnitude, reapply sign
  always_comb begin
    prod_sh = mul_prod >> FRAC_BITS;
    q_mag   = (|prod_sh[PW-1:DW] || prod_sh[DW-1:0] > PROD_LIM) ? PROD_LIM
                                                              : prod_sh[DW-1:0];
    q_val   = mul_neg_r ? -$signed(q_mag) : $signed(q_mag);
  end

  assign stat.unit_done  = mul_done | sqrt_done | div_done;
  assign stat.degenerate = (norm_r[0] <= DW'(tol_r)) || (norm_r[1] <= DW'(tol_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++)
        mat_r[i] <= (i == 0 || i == 5 || i == 10) ? ONE[CW-1:0] : '0;
      tol_r <= 16'd1;
    end else begin
      if (cfg_we) tol_r <= cfg_data;
      case (cmd.op)
        U_LOAD: begin
          cmd_r <= in_user;
          for (int i = 0; i < 5; i++) vin_r[i] <= in_data[i*32 +: 32];
        end
        U_IDENT: begin
          for (int i = 0; i < 12; i++)
            mat_r[i] <= (i == 0 || i == 5 || i == 10) ? ONE[CW-1:0] : '0;
        end
        U_TRANS: begin
          for (int i = 0; i < 3; i++)
            mat_r[i*4+3] <= sat_cw(ext_cw(mat_r[i*4+3]) + DW'(vin_r[i]));
        end
        U_CLRSUM: sum_r <= '0;
        U_CLRACC: acc_r <= '0;
        U_MUL: begin
          mul_dst_r <= cmd.dst;
          mul_neg_r <= a_val[DW-1] ^ b_val[DW-1];
        end
        U_SQRT: sqrt_dst_r <= cmd.dst;
        U_DIV: begin
          div_dst_r <= cmd.dst;
          div_neg_r <= a_val[DW-1];
        end
        U_OMC:    omc_r <= ONE - unit_r[3];
        U_WRNM:   nm_r[cmd.idx] <= sat_cw(acc_r);
        U_COMMIT: for (int i = 0; i < 12; i++) mat_r[i] <= nm_r[i];
        U_ADDT:   if (cmd_r == CMD_POINT) acc_r <= acc_r + ext_cw(mat_r[cmd.idx]);
        U_OUTW:   stage_r[cmd.idx[1:0]] <= sat32(ext_cw(sat_cw(acc_r)));
        U_EMIT:   for (int i = 0; i < 3; i++) out_r[i] <= stage_r[i];
        default: ;
      endcase
      if (mul_done) begin
        case (mul_dst_r.kind)
          DK_SUM:  sum_r <= sum_r + mul_prod[DW-1:0];
          DK_ACC:  acc_r <= acc_r + q_val;
          DK_T:    t_r <= q_val;
          DK_PP:   pp_r[mul_dst_r.idx] <= q_val;
          default: ;
        endcase
      end
      if (sqrt_done) norm_r[sqrt_dst_r.idx[0]] <= sqrt_root;
      if (div_done)
        unit_r[div_dst_r.idx[2:0]] <= div_neg_r ? -$signed(div_quo) : $signed(div_quo);
    end
  end

  assign out_data = {out_r[2], out_r[1], out_r[0]};

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_done, sqrt_done, div_done}))
    else $error("two arithmetic units finished together");

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for affine_transform_engine: a stream driver,
// a result monitor and a fixed-point matrix predictor. Depends on afe_pkg.
`timescale 1ns / 1ps
module tb;
  import afe_pkg::*;

  localparam int FB = 16;
  localparam int CW = 32;
  localparam int N_ITEMS = 400;
  localparam int WATCH_LIMIT = 5000;
  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FB;
  localparam logic signed [31:0] Q32 = 32'sd65536;
  localparam logic [63:0] PROD_LIM = 64'd1 << 61;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] x, y, z, c, s;
    bit                 is_cfg;
    bit                 drain;
    logic [15:0]        tol_val;
  } xf_cmd_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } xf_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  affine_transform_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  xf_cmd_t cmd_q[$];
  xf_res_t expected_q[$];
  logic signed [63:0] mat[12];
  logic [15:0] tol;
  int errors = 0;
  int quiet_cycles = 0;
  int sent = 0;
  logic calm;  // no idling on either side

  assign calm = (sent >= 150) && (sent < 260);

  function automatic logic signed [63:0] sat(logic signed [63:0] v, int w);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic neg;
    logic [63:0] ua, ub, r;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = ua * ub;
    p = p >> FB;
    r = (p[127:64] != 0 || p[63:0] > PROD_LIM) ? PROD_LIM : p[63:0];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else res = res >> 1;
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] sq(logic signed [63:0] v);
    logic [63:0] u;
    u = v < 0 ? -v : v;
    return u * u;
  endfunction

  function automatic void load_identity();
    foreach (mat[i]) mat[i] = 0;
    mat[0] = Q_ONE;
    mat[5] = Q_ONE;
    mat[10] = Q_ONE;
  endfunction

  function automatic void apply_rotation(logic signed [63:0] x, logic signed [63:0] y,
                                         logic signed [63:0] z, logic signed [63:0] c,
                                         logic signed [63:0] s);
    logic [63:0] m, q;
    logic signed [63:0] r[9], nm[12], omc;
    m = int_sqrt(sq(x) + sq(y) + sq(z));
    q = int_sqrt(sq(c) + sq(s));
    if (m <= tol || q <= tol) return;
    x = (x * Q_ONE) / $signed(m);
    y = (y * Q_ONE) / $signed(m);
    z = (z * Q_ONE) / $signed(m);
    c = (c * Q_ONE) / $signed(q);
    s = (s * Q_ONE) / $signed(q);
    omc = Q_ONE - c;
    r[0] = c + fx_mul(fx_mul(x, x), omc);
    r[1] = fx_mul(fx_mul(x, y), omc) - fx_mul(z, s);
    r[2] = fx_mul(fx_mul(x, z), omc) + fx_mul(y, s);
    r[3] = fx_mul(fx_mul(x, y), omc) + fx_mul(z, s);
    r[4] = c + fx_mul(fx_mul(y, y), omc);
    r[5] = fx_mul(fx_mul(y, z), omc) - fx_mul(x, s);
    r[6] = fx_mul(fx_mul(x, z), omc) - fx_mul(y, s);
    r[7] = fx_mul(fx_mul(y, z), omc) + fx_mul(x, s);
    r[8] = c + fx_mul(fx_mul(z, z), omc);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++)
        nm[i*4+j] = sat(fx_mul(r[i*3], mat[j]) + fx_mul(r[i*3+1], mat[4+j])
                        + fx_mul(r[i*3+2], mat[8+j]), CW);
    foreach (mat[i]) mat[i] = nm[i];
  endfunction

  function automatic void predict_command(xf_cmd_t t);
    logic signed [63:0] v[3], acc;
    xf_res_t res;
    v[0] = t.x; v[1] = t.y; v[2] = t.z;
    case (t.cmd)
      CMD_IDENT: load_identity();
      CMD_TRANS: for (int i = 0; i < 3; i++) mat[i*4+3] = sat(mat[i*4+3] + v[i], CW);
      CMD_ROT: apply_rotation(t.x, t.y, t.z, t.c, t.s);
      CMD_POINT, CMD_VEC: begin
        for (int i = 0; i < 3; i++) begin
          acc = fx_mul(mat[i*4], v[0]) + fx_mul(mat[i*4+1], v[1]) + fx_mul(mat[i*4+2], v[2]);
          if (t.cmd == CMD_POINT) acc += mat[i*4+3];
          acc = sat(sat(acc, CW), 32);
          if (i == 0) res.x = acc[31:0];
          else if (i == 1) res.y = acc[31:0];
          else res.z = acc[31:0];
        end
        expected_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    int v;
    case ($urandom_range(9))
      0: v = int'($urandom());
      1: v = 0;
      2: v = int'($urandom_range(6)) - 3;
      default: v = int'($urandom_range(1048575)) - 524288;
    endcase
    return v;
  endfunction

  function automatic xf_cmd_t make_item();
    xf_cmd_t t;
    int k;
    t.is_cfg = 0;
    t.drain = 0;
    t.tol_val = '0;
    t.x = rnd_coord();
    t.y = rnd_coord();
    t.z = rnd_coord();
    t.c = rnd_coord();
    t.s = rnd_coord();
    k = $urandom_range(99);
    if (k < 5) t.cmd = CMD_IDENT;
    else if (k < 20) t.cmd = CMD_TRANS;
    else if (k < 45) begin
      t.cmd = CMD_ROT;
      case ($urandom_range(5))
        0: begin t.c = -Q32; t.s = 0; end  // half turn
        1: begin t.c = Q32; t.s = 0; end
        2: begin t.x = 0; t.y = 0; t.z = Q32; end
        3: begin t.x = 0; t.y = 0; t.z = 0; end
        default: ;
      endcase
    end else if (k < 72) t.cmd = CMD_POINT;
    else if (k < 97) t.cmd = CMD_VEC;
    else t.cmd = 3'($urandom_range(7, 5));
    return t;
  endfunction

  function automatic xf_cmd_t make_cfg(logic [15:0] val);
    xf_cmd_t t;
    t = make_item();
    t.is_cfg = 1;
    t.tol_val = val;
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    xf_cmd_t nxt;
    bit took_in, took_cfg;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      took_in = in_tvalid && in_tready;
      took_cfg = cfg_valid && cfg_ready;
      if (took_in) begin
        predict_command(cmd_q.pop_front());
        sent <= sent + 1;
      end
      if (took_cfg) begin
        tol = cfg_data;
        void'(cmd_q.pop_front());
      end
      if ((!in_tvalid || took_in) && (!cfg_valid || took_cfg)) begin
        in_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        if (cmd_q.size() > 0) begin
          nxt = cmd_q[0];
          if (nxt.is_cfg) begin
            // engine idle and every result taken
            if (!in_tvalid && in_tready && expected_q.size() == 0) begin
              cfg_valid <= 1'b1;
              cfg_data <= nxt.tol_val;
            end
          end else if (nxt.drain && expected_q.size() != 0) begin
            // hold until every expected result has come
          end else if (calm || $urandom_range(99) >= 10) begin
            in_tvalid <= 1'b1;
            in_tuser <= nxt.cmd;
            in_tdata <= {nxt.s, nxt.c, nxt.z, nxt.y, nxt.x};
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    xf_res_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || $urandom_range(99) >= 10;
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_tdata);
        end else begin
          e = expected_q.pop_front();
          if (out_tdata !== {e.z, e.y, e.x}) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, {e.z, e.y, e.x},
                     out_tdata);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCH_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    tol = 16'd1;
    load_identity();
    for (int n = 0; n < N_ITEMS; n++) begin
      if (n == 60) cmd_q.push_back(make_cfg(16'd0));
      else if (n == 150) cmd_q.push_back(make_cfg(16'd65535));
      else if (n == 230) cmd_q.push_back(make_cfg(16'd300));
      else if (n == 320) cmd_q.push_back(make_cfg(16'd1));
      cmd_q.push_back(make_item());
      if (n == 100 || n == 280) cmd_q[$].drain = 1;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_q.size() != 0 || expected_q.size() != 0 || in_tvalid || cfg_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### files.f
rtl/afe_pkg.sv
rtl/afe_mul.sv
rtl/afe_sqrt.sv
rtl/afe_div.sv
rtl/afe_ctrl.sv
rtl/afe_dp.sv
rtl/affine_transform_engine.sv
test/tb.sv
